>>> sv/rc5_pkg.sv
// rc5_pkg: shared types, codes and rotate helpers for the RC5-32 cipher unit.
// Used by rc5_alu, rc5_ctrl, rc5_dpath and rc5_block_cipher_unit.
// Depends on nothing.
package rc5_pkg;

  // Key expansion magic constants
  localparam logic [31:0] P32 = 32'hb7e15163;
  localparam logic [31:0] Q32 = 32'h9e3779b9;

  // Fixed left rotate applied to subkey words during mixing
  localparam logic [4:0] MIX_SHIFT = 5'd3;

  // Number of key bytes the configuration registers can hold
  localparam int KEY_REG_BYTES = 16;

  // Configuration register indexes
  localparam logic [1:0] REG_ROUNDS    = 2'd0;
  localparam logic [1:0] REG_KEY_BYTES = 2'd1;
  localparam logic [1:0] REG_KEY_LOW   = 2'd2;
  localparam logic [1:0] REG_KEY_HIGH  = 2'd3;

  // Data kind codes
  localparam logic KIND_ENCRYPT = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SEED,
    ST_MIX_RD,
    ST_MIX_A,
    ST_MIX_B,
    ST_CIPH_RD,
    ST_CIPH,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MIX_A,
    OP_MIX_B,
    OP_ENC,
    OP_DEC
  } alu_op_t;

  // Sequencer to datapath control group
  typedef struct packed {
    logic    take_item;
    logic    load_key;
    logic    seed_step;
    logic    mix_a;
    logic    mix_b;
    logic    ciph;
    logic    upd_b;
    alu_op_t op;
    logic    out_load;
  } dp_ctrl_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} >> n;
    return t[31:0];
  endfunction

endpackage

>>> sv/rc5_alu.sv
// rc5_alu: the single shared add / xor / rotate unit used for key expansion
// and for every cipher half-round. Depends on rc5_pkg.
module rc5_alu (
  input  rc5_pkg::alu_op_t op,
  input  logic [31:0]      x,
  input  logic [31:0]      y,
  input  logic [31:0]      z,
  output logic [31:0]      res
);

  logic [31:0] sum_xy;
  logic [31:0] sum3;

  assign sum_xy = x + y;
  assign sum3   = sum_xy + z;

  // Select the operation
  always_comb begin
    case (op)
      rc5_pkg::OP_ADD:   res = x + z;
      rc5_pkg::OP_SUB:   res = x - z;
      rc5_pkg::OP_MIX_A: res = rc5_pkg::rotl32(sum3, rc5_pkg::MIX_SHIFT);
      rc5_pkg::OP_MIX_B: res = rc5_pkg::rotl32(sum3, sum_xy[4:0]);
      rc5_pkg::OP_ENC:   res = rc5_pkg::rotl32(x ^ y, y[4:0]) + z;
      rc5_pkg::OP_DEC:   res = rc5_pkg::rotr32(x - z, y[4:0]) ^ y;
      default:           res = x;
    endcase
  end

endmodule

>>> sv/rc5_dpath.sv
// rc5_dpath: subkey memory, key word registers, expansion and block registers
// around the shared rc5_alu. Depends on rc5_pkg and rc5_alu.
module rc5_dpath #(
  parameter int  MAX_ROUNDS    = 16,
  parameter int  MAX_KEY_BYTES = 16,
  localparam int TW            = $clog2(2 * MAX_ROUNDS + 2),
  localparam int KIW           = (((MAX_KEY_BYTES + 3) / 4) > 1) ?
                                 $clog2((MAX_KEY_BYTES + 3) / 4) : 1,
  localparam int BW            = $clog2(MAX_KEY_BYTES + 1)
) (
  input  logic                 clk,
  input  rc5_pkg::dp_ctrl_t    ctl,
  input  logic [TW-1:0]        raddr,
  input  logic [TW-1:0]        waddr,
  input  logic [KIW-1:0]       key_idx,
  input  logic [BW-1:0]        nb,
  input  logic [63:0]          key_low,
  input  logic [63:0]          key_high,
  input  logic [31:0]          word_a,
  input  logic [31:0]          word_b,
  output logic [31:0]          res_a,
  output logic [31:0]          res_b
);

  localparam int TLEN = 2 * MAX_ROUNDS + 2;
  localparam int KW   = (MAX_KEY_BYTES + 3) / 4;

  logic [31:0]  mem [TLEN];
  logic [31:0]  rdata;
  logic [31:0]  lw [KW];
  logic [31:0]  key_init [KW];
  logic [127:0] key_all;
  logic [31:0]  ka, kb, ra, rb, seed;
  logic [31:0]  alu_x, alu_y, alu_z, alu_res;
  logic         mem_we;
  logic [31:0]  mem_wdata;

  assign key_all = {key_high, key_low};

  // Pack valid key bytes into little-endian words, zero past the length
  for (genvar gk = 0; gk < KW; gk++) begin : g_kw
    for (genvar gj = 0; gj < 4; gj++) begin : g_kb
      localparam int BI = 4 * gk + gj;
      if (BI < rc5_pkg::KEY_REG_BYTES) begin : g_reg
        assign key_init[gk][8*gj +: 8] = (32'(nb) > BI) ? key_all[8*BI +: 8] : 8'h00;
      end else begin : g_zero
        assign key_init[gk][8*gj +: 8] = 8'h00;
      end
    end
  end

  // Route operands to the shared unit
  always_comb begin
    alu_x = ra;
    alu_y = rb;
    alu_z = rdata;
    if (ctl.seed_step) begin
      alu_x = seed;
      alu_y = '0;
      alu_z = rc5_pkg::Q32;
    end else if (ctl.mix_a) begin
      alu_x = ka;
      alu_y = kb;
    end else if (ctl.mix_b) begin
      alu_x = ka;
      alu_y = kb;
      alu_z = lw[key_idx];
    end else if (ctl.upd_b) begin
      alu_x = rb;
      alu_y = ra;
    end
  end

  rc5_alu u_alu (
    .op  (ctl.op),
    .x   (alu_x),
    .y   (alu_y),
    .z   (alu_z),
    .res (alu_res)
  );

  // Subkey memory: one write port, one registered read port
  assign mem_we    = ctl.seed_step | ctl.mix_a;
  assign mem_wdata = ctl.seed_step ? seed : alu_res;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= mem_wdata;
    end
    rdata <= mem[raddr];
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (ctl.take_item) begin
      ra <= word_a;
      rb <= word_b;
    end
    if (ctl.load_key) begin
      lw   <= key_init;
      seed <= rc5_pkg::P32;
      ka   <= '0;
      kb   <= '0;
    end
    if (ctl.seed_step) begin
      seed <= alu_res;
    end
    if (ctl.mix_a) begin
      ka <= alu_res;
    end
    if (ctl.mix_b) begin
      kb          <= alu_res;
      lw[key_idx] <= alu_res;
    end
    if (ctl.ciph) begin
      if (ctl.upd_b) begin
        rb <= alu_res;
      end else begin
        ra <= alu_res;
      end
    end
  end

  assign res_a = ra;
  assign res_b = rb;

endmodule

>>> sv/rc5_ctrl.sv
// rc5_ctrl: sequencer for key expansion and the half-round cipher loop,
// with the table, key and step counters. Depends on rc5_pkg.
module rc5_ctrl #(
  parameter int  MAX_ROUNDS    = 16,
  parameter int  MAX_KEY_BYTES = 16,
  localparam int TW            = $clog2(2 * MAX_ROUNDS + 2),
  localparam int KIW           = (((MAX_KEY_BYTES + 3) / 4) > 1) ?
                                 $clog2((MAX_KEY_BYTES + 3) / 4) : 1,
  localparam int BW            = $clog2(MAX_KEY_BYTES + 1),
  localparam int RW            = $clog2(MAX_ROUNDS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic               cfg_we,
  input  logic [RW-1:0]      nr,
  input  logic [BW-1:0]      nb,
  input  logic               out_free,
  output rc5_pkg::dp_ctrl_t  ctl,
  output logic [TW-1:0]      raddr,
  output logic [TW-1:0]      waddr,
  output logic [KIW-1:0]     key_idx
);

  localparam int TLEN = 2 * MAX_ROUNDS + 2;
  localparam int KW   = (MAX_KEY_BYTES + 3) / 4;
  localparam int MAXL = (TLEN > KW) ? TLEN : KW;
  localparam int SW   = $clog2(3 * MAXL + 1);
  localparam int NW   = BW + 2;

  rc5_pkg::state_t state, state_next;

  logic            sched_ready;
  logic            dec;
  logic [TW-1:0]   ti, ti_next, idx, idx_next, tlen_m1, tlen_m1_calc;
  logic [KIW-1:0]  ki, ki_next, klen_m1, klen_m1_calc;
  logic [SW-1:0]   step_cnt, steps_m1_calc, klen_s, tlen_s, max_s;
  logic [NW-1:0]   nb_p3, kl;
  logic            seed_last, step_last, ciph_last;

  // Lengths of the table, the key and the mixing pass
  always_comb begin
    tlen_m1_calc  = TW'({nr, 1'b1});
    nb_p3         = NW'(nb) + NW'(3);
    kl            = nb_p3 >> 2;
    klen_m1_calc  = (kl == '0) ? '0 : KIW'(kl - 1'b1);
    klen_s        = (kl == '0) ? SW'(1) : SW'(kl);
    tlen_s        = SW'(tlen_m1_calc) + 1'b1;
    max_s         = (klen_s > tlen_s) ? klen_s : tlen_s;
    steps_m1_calc = SW'(max_s + (max_s << 1) - 1'b1);
  end

  assign ti_next   = (ti == tlen_m1) ? '0 : ti + 1'b1;
  assign ki_next   = (ki == klen_m1) ? '0 : ki + 1'b1;
  assign idx_next  = dec ? idx - 1'b1 : idx + 1'b1;
  assign seed_last = (ti == tlen_m1);
  assign step_last = (step_cnt == '0);
  assign ciph_last = dec ? (idx == '0) : (idx == tlen_m1);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rc5_pkg::ST_IDLE:
        if (in_valid) begin
          state_next = sched_ready ? rc5_pkg::ST_CIPH_RD : rc5_pkg::ST_LOAD;
        end
      rc5_pkg::ST_LOAD:    state_next = rc5_pkg::ST_SEED;
      rc5_pkg::ST_SEED:
        if (seed_last) begin
          state_next = rc5_pkg::ST_MIX_RD;
        end
      rc5_pkg::ST_MIX_RD:  state_next = rc5_pkg::ST_MIX_A;
      rc5_pkg::ST_MIX_A:   state_next = rc5_pkg::ST_MIX_B;
      rc5_pkg::ST_MIX_B:
        state_next = step_last ? rc5_pkg::ST_CIPH_RD : rc5_pkg::ST_MIX_A;
      rc5_pkg::ST_CIPH_RD: state_next = rc5_pkg::ST_CIPH;
      rc5_pkg::ST_CIPH:
        if (ciph_last) begin
          state_next = rc5_pkg::ST_DONE;
        end
      rc5_pkg::ST_DONE:
        if (out_free) begin
          state_next = rc5_pkg::ST_IDLE;
        end
      default:             state_next = rc5_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl      = '0;
    ctl.op   = rc5_pkg::OP_ADD;
    in_ready = 1'b0;
    raddr    = '0;
    case (state)
      rc5_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        ctl.take_item = in_valid;
      end
      rc5_pkg::ST_LOAD:  ctl.load_key = 1'b1;
      rc5_pkg::ST_SEED:  ctl.seed_step = 1'b1;
      rc5_pkg::ST_MIX_A: begin
        ctl.mix_a = 1'b1;
        ctl.op    = rc5_pkg::OP_MIX_A;
      end
      rc5_pkg::ST_MIX_B: begin
        ctl.mix_b = 1'b1;
        ctl.op    = rc5_pkg::OP_MIX_B;
        raddr     = ti_next;
      end
      rc5_pkg::ST_CIPH_RD: raddr = dec ? tlen_m1 : '0;
      rc5_pkg::ST_CIPH: begin
        ctl.ciph  = 1'b1;
        ctl.upd_b = idx[0];
        if (idx[TW-1:1] == '0) begin
          ctl.op = dec ? rc5_pkg::OP_SUB : rc5_pkg::OP_ADD;
        end else begin
          ctl.op = dec ? rc5_pkg::OP_DEC : rc5_pkg::OP_ENC;
        end
        raddr = ciph_last ? idx : idx_next;
      end
      rc5_pkg::ST_DONE:  ctl.out_load = out_free;
      default:           ctl = '0;
    endcase
  end

  assign waddr   = ti;
  assign key_idx = ki;

  // State and schedule flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rc5_pkg::ST_IDLE;
      sched_ready <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        sched_ready <= 1'b0;
      end else if (state == rc5_pkg::ST_MIX_B && step_last) begin
        sched_ready <= 1'b1;
      end
    end
  end

  // Counters and latched item kind
  always_ff @(posedge clk) begin
    case (state)
      rc5_pkg::ST_IDLE:
        if (in_valid) begin
          dec <= (kind != rc5_pkg::KIND_ENCRYPT);
        end
      rc5_pkg::ST_LOAD: begin
        tlen_m1  <= tlen_m1_calc;
        klen_m1  <= klen_m1_calc;
        step_cnt <= steps_m1_calc;
        ti       <= '0;
      end
      rc5_pkg::ST_SEED:  ti <= ti + 1'b1;
      rc5_pkg::ST_MIX_RD: begin
        ti <= '0;
        ki <= '0;
      end
      rc5_pkg::ST_MIX_B: begin
        ti       <= ti_next;
        ki       <= ki_next;
        step_cnt <= step_cnt - 1'b1;
      end
      rc5_pkg::ST_CIPH_RD: idx <= dec ? tlen_m1 : '0;
      rc5_pkg::ST_CIPH:    idx <= idx_next;
      default: ;
    endcase
  end

endmodule

>>> sv/rc5_block_cipher_unit.sv
// rc5_block_cipher_unit: top level of the RC5-32 ECB cipher with key expansion.
// Depends on rc5_pkg, rc5_ctrl, rc5_dpath (and through it rc5_alu).
//
// Usage:
//   Configuration: write rounds (0), key_bytes (1), key_low (2), key_high (3)
//   through cfg_we / cfg_index / cfg_data while the block is idle. Any write
//   marks the subkey schedule stale.
//   Input channel in_valid/in_ready carries one 64-bit block (word_a, word_b)
//   with kind 0 for encrypt and 1 for decrypt; output channel
//   out_valid/out_ready returns out_a, out_b.
//   One shared add/rotate unit does one half-round per cycle, reading one
//   subkey per cycle from the subkey memory. With r effective rounds, an
//   accepted block passes through ST_CIPH_RD, ST_CIPH and ST_DONE, which
//   loads the output register; a new block is taken only back in idle.
//   The first block after reset or after a configuration write first runs
//   the key expansion: it seeds the table in ST_SEED, then runs
//   3*max(2r+2, key words) mixing steps, each through ST_MIX_A and ST_MIX_B.
//   Reset clears the sequencer, the output valid and the schedule flag;
//   configuration returns to 12 rounds, 16 key bytes and an all-zero key.
//   A result held by a stalled receiver stays in the output register; the
//   next block may be accepted and worked on meanwhile, and it waits in the
//   sequencer until the output register frees.
module rc5_block_cipher_unit #(
  parameter int MAX_ROUNDS    = 16,
  parameter int MAX_KEY_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [31:0] word_a,
  input  logic [31:0] word_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_a,
  output logic [31:0] out_b
);

  localparam int TLEN = 2 * MAX_ROUNDS + 2;
  localparam int TW   = $clog2(TLEN);
  localparam int KW   = (MAX_KEY_BYTES + 3) / 4;
  localparam int KIW  = (KW > 1) ? $clog2(KW) : 1;
  localparam int BW   = $clog2(MAX_KEY_BYTES + 1);
  localparam int RW   = $clog2(MAX_ROUNDS + 1);
  localparam int RCW  = (RW > 5) ? RW : 5;
  localparam int BCW  = (BW > 5) ? BW : 5;

  logic [4:0]        rounds;
  logic [4:0]        key_bytes;
  logic [63:0]       key_low;
  logic [63:0]       key_high;
  logic [RCW-1:0]    rounds_ext;
  logic [BCW-1:0]    key_bytes_ext;
  logic [RW-1:0]     nr;
  logic [BW-1:0]     nb;
  logic              out_free;
  rc5_pkg::dp_ctrl_t ctl;
  logic [TW-1:0]     raddr, waddr;
  logic [KIW-1:0]    key_idx;
  logic [31:0]       res_a, res_b;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rounds    <= 5'd12;
      key_bytes <= 5'd16;
      key_low   <= '0;
      key_high  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rc5_pkg::REG_ROUNDS:    rounds    <= cfg_data[4:0];
        rc5_pkg::REG_KEY_BYTES: key_bytes <= cfg_data[4:0];
        rc5_pkg::REG_KEY_LOW:   key_low   <= cfg_data;
        rc5_pkg::REG_KEY_HIGH:  key_high  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate rounds and key length to the supported maximum
  assign rounds_ext    = RCW'(rounds);
  assign key_bytes_ext = BCW'(key_bytes);
  assign nr = (rounds_ext > RCW'(MAX_ROUNDS)) ? RW'(MAX_ROUNDS) : RW'(rounds_ext);
  assign nb = (key_bytes_ext > BCW'(MAX_KEY_BYTES)) ? BW'(MAX_KEY_BYTES)
                                                     : BW'(key_bytes_ext);

  assign out_free = !out_valid || out_ready;

  rc5_ctrl #(
    .MAX_ROUNDS    (MAX_ROUNDS),
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .cfg_we   (cfg_we),
    .nr       (nr),
    .nb       (nb),
    .out_free (out_free),
    .ctl      (ctl),
    .raddr    (raddr),
    .waddr    (waddr),
    .key_idx  (key_idx)
  );

  rc5_dpath #(
    .MAX_ROUNDS    (MAX_ROUNDS),
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dpath (
    .clk      (clk),
    .ctl      (ctl),
    .raddr    (raddr),
    .waddr    (waddr),
    .key_idx  (key_idx),
    .nb       (nb),
    .key_low  (key_low),
    .key_high (key_high),
    .word_a   (word_a),
    .word_b   (word_b),
    .res_a    (res_a),
    .res_b    (res_b)
  );

  // Output register: load a finished block, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_a <= res_a;
      out_b <= res_b;
    end
  end

endmodule

>>> sv/rc5_checker.sv
// rc5_checker: port-level assertions for rc5_block_cipher_unit, attached
// with a bind statement. Depends on rc5_block_cipher_unit.
module rc5_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_a,
  input logic [31:0] out_b
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_a) && $stable(out_b))
    else $error("stalled result changed or dropped");

  // Come out of reset idle and empty
  a_reset_idle: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  // Stay busy in the cycle after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken back to back");

  // No result appears in the cycle after acceptance
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early after acceptance");

  // A new result coincides with the sequencer returning to idle
  a_ready_on_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result shown while sequencer busy");

endmodule

bind rc5_block_cipher_unit rc5_checker u_rc5_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_a     (out_a),
  .out_b     (out_b)
);
